FILE: rtl/core/rpn_pkg.sv
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared types, constants and helpers for the rpn stack calculator.
// ----------------------------------------------------------------------------
package rpn_pkg;

  localparam int VAL_W           = 48;
  localparam int PROD_W          = 2 * VAL_W;
  localparam int DEPTH_W         = 8;
  localparam int STACK_DEPTH_DEF = 128;
  localparam int FRAC_BITS_DEF   = 16;

  typedef enum logic [2:0] {
    MODE_PUSH    = 3'd0,
    MODE_ADD     = 3'd1,
    MODE_SUB     = 3'd2,
    MODE_MUL     = 3'd3,
    MODE_DIV     = 3'd4,
    MODE_MOD     = 3'd5,
    MODE_POP     = 3'd6,
    MODE_UNKNOWN = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    MDU_MUL = 2'd0,
    MDU_DIV = 2'd1,
    MDU_MOD = 2'd2
  } mdu_op_t;

  typedef struct packed {
    mode_t                    mode;
    logic signed [VAL_W-1:0]  number;
  } in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0]  value;
    logic                     report_valid;
    logic                     stack_full;
    logic                     stack_empty;
    logic                     divide_by_zero;
    logic                     unknown_command;
    logic                     saturated;
    logic [DEPTH_W-1:0]       depth;
  } out_t;

  typedef struct packed {
    logic    start;
    mdu_op_t op;
  } mdu_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [VAL_W-1:0]  value;
    logic                     sat;
  } mdu_rsp_t;

  typedef struct packed {
    logic                     sat;
    logic signed [VAL_W-1:0]  value;
  } clip_t;

  localparam logic [PROD_W-1:0] NEG_LIMIT =
    {{(PROD_W-VAL_W){1'b0}}, 1'b1, {(VAL_W-1){1'b0}}};
  localparam logic [PROD_W-1:0] POS_LIMIT = NEG_LIMIT - 1'b1;
  localparam logic [VAL_W-1:0]  VAL_MIN   = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic [VAL_W-1:0]  VAL_MAX   = {1'b0, {(VAL_W-1){1'b1}}};

  function automatic logic [VAL_W-1:0] mag_of(input logic [VAL_W-1:0] x);
    mag_of = x[VAL_W-1] ? (~x + 1'b1) : x;
  endfunction

  // sign and magnitude back to a clipped two's complement value
  function automatic clip_t clip_fn(input logic neg, input logic [PROD_W-1:0] mag);
    clip_t            r;
    logic [VAL_W-1:0] mag_n;
    mag_n = ~mag[VAL_W-1:0] + 1'b1;
    r.sat = 1'b0;
    if (neg) begin
      if (mag > NEG_LIMIT) begin
        r.sat   = 1'b1;
        r.value = VAL_MIN;
      end else begin
        r.value = mag_n;
      end
    end else begin
      if (mag > POS_LIMIT) begin
        r.sat   = 1'b1;
        r.value = VAL_MAX;
      end else begin
        r.value = mag[VAL_W-1:0];
      end
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/rpn_ram.sv
// ----------------------------------------------------------------------------
// rpn_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module rpn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/rpn_mdu.sv
// ----------------------------------------------------------------------------
// rpn_mdu
// Iterative multiply / divide unit: shift-add multiply one bit per cycle,
// restoring divide and remainder one quotient bit per cycle, then sign and saturation.
// ----------------------------------------------------------------------------
module rpn_mdu #(
  parameter int FRAC_BITS = rpn_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  rpn_pkg::mdu_req_t                req,
  input  logic signed [rpn_pkg::VAL_W-1:0] l_val,
  input  logic signed [rpn_pkg::VAL_W-1:0] r_val,
  output rpn_pkg::mdu_rsp_t                rsp
);

  localparam int VW    = rpn_pkg::VAL_W;
  localparam int PW    = rpn_pkg::PROD_W;
  localparam int NW    = VW + FRAC_BITS;
  localparam int CNT_W = $clog2(NW + 1);

  typedef enum logic [2:0] {
    M_IDLE = 3'b001,
    M_RUN  = 3'b010,
    M_FIN  = 3'b100
  } mstate_t;

  mstate_t           state_r, state_nxt;
  rpn_pkg::mdu_op_t  op_r, op_nxt;
  logic              neg_r, neg_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [PW-1:0]     p_r, p_nxt;
  logic [VW-1:0]     mcand_r, mcand_nxt;
  logic [NW-1:0]     q_r, q_nxt;
  logic [VW-1:0]     d_r, d_nxt;
  logic [VW-1:0]     rem_r, rem_nxt;
  rpn_pkg::mdu_rsp_t rsp_r, rsp_nxt;

  logic [VW-1:0]     mag_l, mag_r;
  logic [VW-1:0]     addend;
  logic [VW:0]       mul_sum;
  logic [VW:0]       trial;
  logic [VW:0]       trial_diff;
  logic              ge;
  logic [VW-1:0]     mod_m;
  rpn_pkg::clip_t    clip_res;

  assign mag_l      = rpn_pkg::mag_of(l_val);
  assign mag_r      = rpn_pkg::mag_of(r_val);
  assign addend     = p_r[0] ? mcand_r : '0;
  assign mul_sum    = {1'b0, p_r[PW-1:VW]} + {1'b0, addend};
  assign trial      = {rem_r, q_r[NW-1]};
  assign trial_diff = trial - {1'b0, d_r};
  assign ge         = trial >= {1'b0, d_r};
  assign mod_m      = rem_r << FRAC_BITS;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    neg_nxt   = neg_r;
    cnt_nxt   = cnt_r;
    p_nxt     = p_r;
    mcand_nxt = mcand_r;
    q_nxt     = q_r;
    d_nxt     = d_r;
    rem_nxt   = rem_r;
    rsp_nxt   = rsp_r;
    rsp_nxt.done = 1'b0;
    clip_res  = rpn_pkg::clip_fn(neg_r, p_r >> FRAC_BITS);

    unique case (state_r)
      M_IDLE: begin
        if (req.start) begin
          op_nxt    = req.op;
          state_nxt = M_RUN;
          rem_nxt   = '0;
          case (req.op)
            rpn_pkg::MDU_MUL: begin
              neg_nxt   = l_val[VW-1] ^ r_val[VW-1];
              p_nxt     = {{VW{1'b0}}, mag_l};
              mcand_nxt = mag_r;
              cnt_nxt   = CNT_W'(VW);
            end
            rpn_pkg::MDU_DIV: begin
              neg_nxt = l_val[VW-1] ^ r_val[VW-1];
              q_nxt   = NW'(mag_l) << FRAC_BITS;
              d_nxt   = mag_r;
              cnt_nxt = CNT_W'(NW);
            end
            default: begin
              // remainder of the integer parts, sign of the dividend
              neg_nxt = l_val[VW-1];
              q_nxt   = NW'(mag_l >> FRAC_BITS);
              d_nxt   = mag_r >> FRAC_BITS;
              cnt_nxt = CNT_W'(NW);
            end
          endcase
        end
      end
      M_RUN: begin
        if (op_r == rpn_pkg::MDU_MUL) begin
          p_nxt = {mul_sum, p_r[VW-1:1]};
        end else begin
          q_nxt   = {q_r[NW-2:0], ge};
          rem_nxt = ge ? trial_diff[VW-1:0] : trial[VW-1:0];
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = M_FIN;
        end
      end
      M_FIN: begin
        case (op_r)
          rpn_pkg::MDU_MUL: clip_res = rpn_pkg::clip_fn(neg_r, p_r >> FRAC_BITS);
          rpn_pkg::MDU_DIV: clip_res = rpn_pkg::clip_fn(neg_r, PW'(q_r));
          default: begin
            clip_res.sat   = 1'b0;
            clip_res.value = neg_r ? (~mod_m + 1'b1) : mod_m;
          end
        endcase
        rsp_nxt.done  = 1'b1;
        rsp_nxt.value = clip_res.value;
        rsp_nxt.sat   = clip_res.sat;
        state_nxt     = M_IDLE;
      end
      default: state_nxt = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= M_IDLE;
      rsp_r.done <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      rsp_r.done <= rsp_nxt.done;
    end
    op_r        <= op_nxt;
    neg_r       <= neg_nxt;
    cnt_r       <= cnt_nxt;
    p_r         <= p_nxt;
    mcand_r     <= mcand_nxt;
    q_r         <= q_nxt;
    d_r         <= d_nxt;
    rem_r       <= rem_nxt;
    rsp_r.value <= rsp_nxt.value;
    rsp_r.sat   <= rsp_nxt.sat;
  end

  assign rsp = rsp_r;

endmodule

FILE: rtl/core/rpn_stack_calculator_top.sv
// Push and unknown tokens report in the cycle after acceptance; pop, divide-by-zero,
// add and subtract report after the stack reads that they need; multiply runs a
// 48-step shift-add, divide and remainder one quotient bit per cycle.
// One token at a time: busy is high from acceptance of a pop or arithmetic
// token until its result strobes. Results strobe for one cycle and cannot be stalled.
// Reset (synchronous, rst_n low) empties the stack; the stack RAM is not cleared.
// ----------------------------------------------------------------------------
// rpn_stack_calculator_top
// Reverse Polish calculator over a RAM-held operand stack of Q31.16 values.
// ----------------------------------------------------------------------------
module rpn_stack_calculator_top #(
  parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF,
  parameter int FRAC_BITS   = rpn_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  rpn_pkg::in_t  in_item,
  output logic          out_strobe,
  output rpn_pkg::out_t out_item
);

  localparam int VW   = rpn_pkg::VAL_W;
  localparam int AW   = $clog2(STACK_DEPTH);
  localparam int SP_W = $clog2(STACK_DEPTH + 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RDR  = 6'b000010,
    S_CHKR = 6'b000100,
    S_RDL  = 6'b001000,
    S_EXEC = 6'b010000,
    S_WAIT = 6'b100000
  } state_t;

  state_t                state_r, state_nxt;
  logic [SP_W-1:0]       sp_r, sp_nxt;
  rpn_pkg::mode_t        mode_r, mode_nxt;
  logic signed [VW-1:0]  l_r, l_nxt;
  logic signed [VW-1:0]  r_r, r_nxt;
  logic                  empty_r, empty_nxt;
  rpn_pkg::out_t         out_r, out_nxt;
  logic                  strobe_r, strobe_nxt;

  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [VW-1:0]         ram_wdata, ram_rdata;
  rpn_pkg::mdu_req_t     mdu_req;
  rpn_pkg::mdu_rsp_t     mdu_rsp;

  logic [SP_W-1:0]       sp_dec;
  logic [SP_W-1:0]       sp_inc;
  logic                  sp_full;
  logic [VW-1:0]         mag_rr;
  logic [VW:0]           l_ext, r_ext, sum;
  logic signed [VW-1:0]  sum_val;
  logic                  sum_ovf;

  assign sp_dec  = sp_r - 1'b1;
  assign sp_inc  = sp_r + 1'b1;
  assign sp_full = sp_r == SP_W'(STACK_DEPTH);
  assign mag_rr  = rpn_pkg::mag_of(r_r);
  assign l_ext   = {l_r[VW-1], l_r};
  assign r_ext   = {r_r[VW-1], r_r};
  assign sum     = (mode_r == rpn_pkg::MODE_SUB) ? (l_ext - r_ext) : (l_ext + r_ext);
  assign sum_ovf = sum[VW] != sum[VW-1];
  assign sum_val = sum_ovf ? (sum[VW] ? rpn_pkg::VAL_MIN : rpn_pkg::VAL_MAX) : sum[VW-1:0];

  always_comb begin
    state_nxt   = state_r;
    sp_nxt      = sp_r;
    mode_nxt    = mode_r;
    l_nxt       = l_r;
    r_nxt       = r_r;
    empty_nxt   = empty_r;
    out_nxt     = out_r;
    strobe_nxt  = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = sp_r[AW-1:0];
    ram_wdata   = in_item.number;
    ram_re      = 1'b0;
    ram_raddr   = sp_dec[AW-1:0];
    mdu_req.start = 1'b0;
    mdu_req.op    = rpn_pkg::MDU_MUL;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          mode_nxt  = in_item.mode;
          empty_nxt = 1'b0;
          out_nxt   = '0;
          case (in_item.mode)
            rpn_pkg::MODE_PUSH: begin
              out_nxt.value = in_item.number;
              strobe_nxt    = 1'b1;
              if (sp_full) begin
                out_nxt.stack_full = 1'b1;
              end else begin
                ram_we = 1'b1;
                sp_nxt = sp_inc;
              end
            end
            rpn_pkg::MODE_UNKNOWN: begin
              out_nxt.unknown_command = 1'b1;
              strobe_nxt              = 1'b1;
            end
            default: begin
              // first pop: right operand, or the reported value
              if (sp_r == '0) begin
                r_nxt     = '0;
                empty_nxt = 1'b1;
                state_nxt = S_CHKR;
              end else begin
                ram_re    = 1'b1;
                sp_nxt    = sp_dec;
                state_nxt = S_RDR;
              end
            end
          endcase
        end
      end
      S_RDR: begin
        r_nxt     = ram_rdata;
        state_nxt = S_CHKR;
      end
      S_CHKR: begin
        if (mode_r == rpn_pkg::MODE_POP) begin
          out_nxt.value        = r_r;
          out_nxt.report_valid = 1'b1;
          strobe_nxt           = 1'b1;
          state_nxt            = S_IDLE;
        end else if ((mode_r == rpn_pkg::MODE_DIV && r_r == '0) ||
                     (mode_r == rpn_pkg::MODE_MOD && (mag_rr >> FRAC_BITS) == '0)) begin
          // divisor stays consumed, dividend untouched
          out_nxt.divide_by_zero = 1'b1;
          strobe_nxt             = 1'b1;
          state_nxt              = S_IDLE;
        end else if (sp_r == '0) begin
          l_nxt     = '0;
          empty_nxt = 1'b1;
          state_nxt = S_EXEC;
        end else begin
          ram_re    = 1'b1;
          sp_nxt    = sp_dec;
          state_nxt = S_RDL;
        end
      end
      S_RDL: begin
        l_nxt     = ram_rdata;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        case (mode_r)
          rpn_pkg::MODE_ADD, rpn_pkg::MODE_SUB: begin
            out_nxt.value     = sum_val;
            out_nxt.saturated = sum_ovf;
            ram_we            = 1'b1;
            ram_wdata         = sum_val;
            sp_nxt            = sp_inc;
            strobe_nxt        = 1'b1;
            state_nxt         = S_IDLE;
          end
          rpn_pkg::MODE_MUL: begin
            mdu_req.start = 1'b1;
            mdu_req.op    = rpn_pkg::MDU_MUL;
            state_nxt     = S_WAIT;
          end
          rpn_pkg::MODE_DIV: begin
            mdu_req.start = 1'b1;
            mdu_req.op    = rpn_pkg::MDU_DIV;
            state_nxt     = S_WAIT;
          end
          default: begin
            mdu_req.start = 1'b1;
            mdu_req.op    = rpn_pkg::MDU_MOD;
            state_nxt     = S_WAIT;
          end
        endcase
      end
      S_WAIT: begin
        if (mdu_rsp.done) begin
          out_nxt.value     = mdu_rsp.value;
          out_nxt.saturated = mdu_rsp.sat;
          ram_we            = 1'b1;
          ram_wdata         = mdu_rsp.value;
          sp_nxt            = sp_inc;
          strobe_nxt        = 1'b1;
          state_nxt         = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (strobe_nxt) begin
      out_nxt.stack_empty = empty_nxt;
      out_nxt.depth       = rpn_pkg::DEPTH_W'(sp_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      sp_r     <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      sp_r     <= sp_nxt;
      strobe_r <= strobe_nxt;
    end
    mode_r  <= mode_nxt;
    l_r     <= l_nxt;
    r_r     <= r_nxt;
    empty_r <= empty_nxt;
    out_r   <= out_nxt;
  end

  rpn_ram #(
    .WIDTH (VW),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rpn_mdu #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mdu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mdu_req),
    .l_val (l_r),
    .r_val (r_r),
    .rsp   (mdu_rsp)
  );

  assign busy       = state_r != S_IDLE;
  assign out_strobe = strobe_r;
  assign out_item   = out_r;

endmodule
